/* sv/srpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package srpr_pkg;

  localparam int NUM_REGS  = 7;
  localparam int NUM_ROT   = 9;
  localparam int NUM_PROD  = 10;

  typedef logic signed [31:0] word_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_QUAT_W  = 3'd0,
    REG_QUAT_X  = 3'd1,
    REG_QUAT_Y  = 3'd2,
    REG_QUAT_Z  = 3'd3,
    REG_TRANS_X = 3'd4,
    REG_TRANS_Y = 3'd5,
    REG_TRANS_Z = 3'd6
  } reg_idx_t;

  localparam word_t QUAT_W_RESET  = 32'sd1073741824;
  localparam word_t TRANS_Z_RESET = 32'sd32768000;

  // Rotation sequencer states.
  typedef enum logic [6:0] {
    SEQ_LOAD = 7'b0000001,
    SEQ_NORM = 7'b0000010,
    SEQ_MUL  = 7'b0000100,
    SEQ_SUMN = 7'b0001000,
    SEQ_NUM  = 7'b0010000,
    SEQ_DIV  = 7'b0100000,
    SEQ_DONE = 7'b1000000
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rot_stat_t;

  // Add half an LSB of Q30 and drop 30 fraction bits (floor).
  function automatic logic signed [35:0] rnd_q30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    return t[65:30];
  endfunction

  function automatic word_t sat32(input logic signed [65:0] v);
    word_t r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/srpr_rot.sv */
`timescale 1ns / 1ps
`default_nettype none
module srpr_rot (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  srpr_pkg::word_t       quat   [4],
  output srpr_pkg::rot_stat_t   stat,
  output srpr_pkg::word_t       rot    [9]
);
  import srpr_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [31:0]        mag_r [4];
  logic [31:0]        mag_nxt [4];
  logic               sgn_r [4];
  logic               sgn_nxt [4];
  logic signed [63:0] prod_r [NUM_PROD];
  logic [63:0]        n_r, n_nxt;
  logic [63:0]        rem_r, rem_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic               neg_r, neg_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [4:0]         step_r, step_nxt;
  logic               zero_r, zero_nxt;
  word_t              rot_r [NUM_ROT];

  logic [31:0]        m01, m23, mmax;
  word_t              opa, opb;
  logic signed [63:0] num;
  logic [63:0]        rem_sh;
  logic               ge;
  logic [32:0]        qp1;
  word_t              qval;

  function automatic word_t sq(input logic [31:0] mag, input logic sgn);
    return sgn ? -$signed(mag) : $signed(mag);
  endfunction

  always_comb begin
    m01  = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    m23  = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    mmax = (m01 > m23) ? m01 : m23;
  end

  // Product order: ww xx yy zz xy wz xz wy yz wx.
  always_comb begin
    case (cnt_r)
      4'd0: begin opa = sq(mag_r[0], sgn_r[0]); opb = sq(mag_r[0], sgn_r[0]); end
      4'd1: begin opa = sq(mag_r[1], sgn_r[1]); opb = sq(mag_r[1], sgn_r[1]); end
      4'd2: begin opa = sq(mag_r[2], sgn_r[2]); opb = sq(mag_r[2], sgn_r[2]); end
      4'd3: begin opa = sq(mag_r[3], sgn_r[3]); opb = sq(mag_r[3], sgn_r[3]); end
      4'd4: begin opa = sq(mag_r[1], sgn_r[1]); opb = sq(mag_r[2], sgn_r[2]); end
      4'd5: begin opa = sq(mag_r[0], sgn_r[0]); opb = sq(mag_r[3], sgn_r[3]); end
      4'd6: begin opa = sq(mag_r[1], sgn_r[1]); opb = sq(mag_r[3], sgn_r[3]); end
      4'd7: begin opa = sq(mag_r[0], sgn_r[0]); opb = sq(mag_r[2], sgn_r[2]); end
      4'd8: begin opa = sq(mag_r[2], sgn_r[2]); opb = sq(mag_r[3], sgn_r[3]); end
      4'd9: begin opa = sq(mag_r[0], sgn_r[0]); opb = sq(mag_r[1], sgn_r[1]); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    case (cnt_r)
      4'd0: num = prod_r[0] + prod_r[1] - prod_r[2] - prod_r[3];
      4'd1: num = (prod_r[4] - prod_r[5]) <<< 1;
      4'd2: num = (prod_r[6] + prod_r[7]) <<< 1;
      4'd3: num = (prod_r[4] + prod_r[5]) <<< 1;
      4'd4: num = prod_r[0] - prod_r[1] + prod_r[2] - prod_r[3];
      4'd5: num = (prod_r[8] - prod_r[9]) <<< 1;
      4'd6: num = (prod_r[6] - prod_r[7]) <<< 1;
      4'd7: num = (prod_r[8] + prod_r[9]) <<< 1;
      4'd8: num = prod_r[0] - prod_r[1] - prod_r[2] + prod_r[3];
      default: num = '0;
    endcase
  end

  always_comb begin
    rem_sh = (step_r == 5'd0) ? rem_r : {rem_r[62:0], 1'b0};
    ge     = rem_sh >= n_r;
    qp1    = {1'b0, quo_r[30:0], ge} + 33'd1;
    qval   = neg_r ? -$signed(qp1[32:1]) : $signed(qp1[32:1]);
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    sgn_nxt   = sgn_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    zero_nxt  = zero_r;
    case (state_r)
      SEQ_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          sgn_nxt[i] = quat[i][31];
          mag_nxt[i] = quat[i][31] ? 32'(-quat[i]) : 32'(quat[i]);
        end
        zero_nxt  = 1'b0;
        state_nxt = SEQ_NORM;
      end
      SEQ_NORM: begin
        cnt_nxt = 4'd0;
        if (mmax == 32'd0) begin
          zero_nxt  = 1'b1;
          state_nxt = SEQ_DONE;
        end else if (mmax > 32'h4000_0000) begin
          for (int i = 0; i < 4; i++) mag_nxt[i] = mag_r[i] >> 1;
          state_nxt = SEQ_MUL;
        end else if (mmax <= 32'h2000_0000) begin
          for (int i = 0; i < 4; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          state_nxt = SEQ_MUL;
        end
      end
      SEQ_MUL: begin
        if (cnt_r == 4'(NUM_PROD - 1)) begin
          state_nxt = SEQ_SUMN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      SEQ_SUMN: begin
        n_nxt     = 64'(prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3]);
        cnt_nxt   = 4'd0;
        state_nxt = SEQ_NUM;
      end
      SEQ_NUM: begin
        neg_nxt   = num[63];
        rem_nxt   = num[63] ? 64'(-num) : 64'(num);
        quo_nxt   = '0;
        step_nxt  = 5'd0;
        state_nxt = SEQ_DIV;
      end
      SEQ_DIV: begin
        rem_nxt  = ge ? rem_sh - n_r : rem_sh;
        quo_nxt  = {quo_r[30:0], ge};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          if (cnt_r == 4'(NUM_ROT - 1)) begin
            state_nxt = SEQ_DONE;
          end else begin
            cnt_nxt   = cnt_r + 4'd1;
            state_nxt = SEQ_NUM;
          end
        end
      end
      SEQ_DONE: begin
      end
      default: state_nxt = SEQ_LOAD;
    endcase
    if (start) state_nxt = SEQ_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    sgn_r  <= sgn_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
    zero_r <= zero_nxt;
    if (state_r == SEQ_MUL) prod_r[cnt_r] <= opa * opb;
    if (state_r == SEQ_DIV && step_r == 5'd31) rot_r[cnt_r] <= qval;
  end

  assign stat.busy = (state_r != SEQ_DONE);
  assign stat.zero = zero_r;
  assign rot       = rot_r;

endmodule
`default_nettype wire

/* sv/stereo_ray_pose_residual.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stereo two-ray pose residual. The pose is an unnormalized quaternion and a
// translation held in seven configuration registers. Each input item carries
// a model point and a left and a right viewing ray; the block moves the point
// by the pose and returns, as one item, the cross product of the vector from
// each ray's origin to the moved point with that ray's direction, in
// saturated Q16.16. The left ray starts at the origin. Items flow through a
// six-stage pipeline and one item is taken every cycle unless the rotation
// is being rebuilt or the output stalls. After reset and after every write to
// a quaternion register the rotation matrix is rebuilt by a sequencer with
// one shared multiplier and a one-bit-per-cycle divider (scaling, 10
// products, then a division for each of the nine entries), during which
// in_tready stays low. Translation writes take effect at once. A quaternion
// of all zeros yields all-zero residuals.
module stereo_ray_pose_residual (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: point_x, point_y, point_z, left_dir_x, left_dir_y,
  // left_dir_z, right_org_x, right_org_y, right_org_z, right_dir_x,
  // right_dir_y, right_dir_z; 32 bits each.
  input  wire [383:0]  in_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  // Fields from bit 0 up: left_res_x, left_res_y, left_res_z, right_res_x,
  // right_res_y, right_res_z; 32 bits each.
  output logic [191:0] out_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire [2:0]    cfg_index,
  input  wire [31:0]   cfg_data
);
  import srpr_pkg::*;

  word_t      quat_r [4];
  word_t      trans_r [3];
  word_t      rot [NUM_ROT];
  rot_stat_t  stat;
  logic       cfg_fire, quat_wr;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign quat_wr   = cfg_fire & (cfg_index == REG_QUAT_W || cfg_index == REG_QUAT_X ||
                                 cfg_index == REG_QUAT_Y || cfg_index == REG_QUAT_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[0]  <= QUAT_W_RESET;
      quat_r[1]  <= '0;
      quat_r[2]  <= '0;
      quat_r[3]  <= '0;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= TRANS_Z_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_QUAT_W:  quat_r[0]  <= cfg_data;
        REG_QUAT_X:  quat_r[1]  <= cfg_data;
        REG_QUAT_Y:  quat_r[2]  <= cfg_data;
        REG_QUAT_Z:  quat_r[3]  <= cfg_data;
        REG_TRANS_X: trans_r[0] <= cfg_data;
        REG_TRANS_Y: trans_r[1] <= cfg_data;
        REG_TRANS_Z: trans_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  srpr_rot u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (quat_wr),
    .quat  (quat_r),
    .stat  (stat),
    .rot   (rot)
  );

  // Pipeline valid bits; a stage takes new data when it is empty or the
  // stage after it moves on.
  logic [6:1] v_r;
  logic [6:1] rdy;

  always_comb begin
    rdy[6] = !v_r[6] || out_tready;
    for (int k = 5; k >= 1; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_tready = rdy[1] & !stat.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_tvalid & in_tready;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  word_t              pt [3], ld [3], ro [3], rd [3];
  logic signed [63:0] prod1_r [NUM_ROT];
  word_t              ld1_r [3], ro1_r [3], rd1_r [3];
  logic signed [35:0] s2_r [3];
  word_t              ld2_r [3], ro2_r [3], rd2_r [3];
  word_t              p3_r [3], ld3_r [3], ro3_r [3], rd3_r [3];
  word_t              p4_r [3], dr4_r [3], ld4_r [3], rd4_r [3];
  logic signed [63:0] la5_r [3], lb5_r [3], ra5_r [3], rb5_r [3];
  word_t              res_r [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = in_tdata[32*i +: 32];
      ld[i] = in_tdata[32*(3+i) +: 32];
      ro[i] = in_tdata[32*(6+i) +: 32];
      rd[i] = in_tdata[32*(9+i) +: 32];
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: rotation products.
    if (rdy[1]) begin
      for (int i = 0; i < NUM_ROT; i++) prod1_r[i] <= rot[i] * pt[i % 3];
      ld1_r <= ld;
      ro1_r <= ro;
      rd1_r <= rd;
    end
    // Stage 2: row sums rounded to Q16.16.
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_r[i] <= rnd_q30(66'(prod1_r[3*i]) + 66'(prod1_r[3*i+1]) + 66'(prod1_r[3*i+2]));
      end
      ld2_r <= ld1_r;
      ro2_r <= ro1_r;
      rd2_r <= rd1_r;
    end
    // Stage 3: add the translation.
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) p3_r[i] <= sat32(66'(s2_r[i]) + 66'(trans_r[i]));
      ld3_r <= ld2_r;
      ro3_r <= ro2_r;
      rd3_r <= rd2_r;
    end
    // Stage 4: vector from the right ray origin.
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) dr4_r[i] <= sat32(66'(p3_r[i]) - 66'(ro3_r[i]));
      p4_r  <= p3_r;
      ld4_r <= ld3_r;
      rd4_r <= rd3_r;
    end
    // Stage 5: cross product terms.
    if (rdy[5]) begin
      for (int c = 0; c < 3; c++) begin
        la5_r[c] <= p4_r[(c+1)%3] * ld4_r[(c+2)%3];
        lb5_r[c] <= p4_r[(c+2)%3] * ld4_r[(c+1)%3];
        ra5_r[c] <= dr4_r[(c+1)%3] * rd4_r[(c+2)%3];
        rb5_r[c] <= dr4_r[(c+2)%3] * rd4_r[(c+1)%3];
      end
    end
    // Stage 6: difference, rounding and saturation into the output register.
    if (rdy[6]) begin
      for (int c = 0; c < 3; c++) begin
        res_r[c]   <= stat.zero ? '0 :
                      sat32(66'(rnd_q30(66'(la5_r[c]) - 66'(lb5_r[c]))));
        res_r[3+c] <= stat.zero ? '0 :
                      sat32(66'(rnd_q30(66'(ra5_r[c]) - 66'(rb5_r[c]))));
      end
    end
  end

  assign out_tvalid = v_r[6];

  always_comb begin
    for (int i = 0; i < 6; i++) out_tdata[32*i +: 32] = res_r[i];
  end

endmodule
`default_nettype wire
